@@ design/gbs_pkg.sv @@
// Shared constants, record types and register codes for the greedy box suppression block.
// No dependencies; every other design file imports this package.
package gbs_pkg;

    localparam int MAX_KEPT    = 64;
    localparam int COORD_WIDTH = 16;

    localparam int EXT_W   = COORD_WIDTH - 1;   // width / height / overlap
    localparam int EDGE_W  = COORD_WIDTH + 1;   // edges at full precision
    localparam int AREA_W  = 2 * EXT_W;
    localparam int SUM_W   = AREA_W + 1;        // area sum and union
    localparam int THR_W   = 16;
    localparam int PROD_W  = THR_W + SUM_W;
    localparam int LHS_W   = AREA_W + THR_W;    // inter << 16

    localparam int INDEX_W = 14;
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    localparam int APB_AW = 3;
    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    // register index codes (paddr bit 2 selects the register)
    localparam logic REG_IOU_THRESHOLD = 1'b0;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x0;
        logic signed [EDGE_W-1:0] y0;
        logic signed [EDGE_W-1:0] x1;
        logic signed [EDGE_W-1:0] y1;
        logic        [AREA_W-1:0] area;
    } kept_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } iou_stat_t;

endpackage

@@ design/gbs_cell.sv @@
// One cell of the kept-box ring: holds a stored box and its area.
// Depends on gbs_pkg for the record type.
module gbs_cell (
    input  logic          aclk,
    input  logic          shift,
    input  logic          load,
    input  gbs_pkg::kept_t nbr_in,
    input  gbs_pkg::kept_t new_in,
    output gbs_pkg::kept_t rec_out
);
    import gbs_pkg::*;

    kept_t rec_reg;
    kept_t rec_next;

    always_comb begin
        rec_next = rec_reg;
        if (load) begin
            rec_next = new_in;
        end else if (shift) begin
            rec_next = nbr_in;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec_out = rec_reg;

endmodule

@@ design/gbs_iou.sv @@
// Pipelined overlap test: candidate against one stored box per cycle, four stages.
// Depends on gbs_pkg for the record and status types.
module gbs_iou (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_tag,
    input  gbs_pkg::kept_t           cand,
    input  gbs_pkg::kept_t           stored,
    input  logic [gbs_pkg::THR_W-1:0] threshold,
    output gbs_pkg::iou_stat_t       stat
);
    import gbs_pkg::*;

    // stage 1: overlap extents and area sum
    logic             tag1_reg;
    logic [EXT_W-1:0] ox_reg, oy_reg;
    logic [SUM_W-1:0] sum1_reg;
    // stage 2: intersection
    logic              tag2_reg;
    logic [AREA_W-1:0] inter2_reg;
    logic [SUM_W-1:0]  sum2_reg;
    // stage 3: union
    logic              tag3_reg;
    logic [AREA_W-1:0] inter3_reg;
    logic [SUM_W-1:0]  uni3_reg;
    // stage 4: threshold times union
    logic              tag4_reg;
    logic [AREA_W-1:0] inter4_reg;
    logic [PROD_W-1:0] prod4_reg;

    logic signed [EDGE_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [EDGE_W:0]   dx, dy;
    logic [EXT_W-1:0]         ox_next, oy_next;
    logic [LHS_W-1:0]         lhs;

    always_comb begin
        lo_x = (cand.x0 > stored.x0) ? cand.x0 : stored.x0;
        hi_x = (cand.x1 < stored.x1) ? cand.x1 : stored.x1;
        lo_y = (cand.y0 > stored.y0) ? cand.y0 : stored.y0;
        hi_y = (cand.y1 < stored.y1) ? cand.y1 : stored.y1;
        dx   = {hi_x[EDGE_W-1], hi_x} - {lo_x[EDGE_W-1], lo_x};
        dy   = {hi_y[EDGE_W-1], hi_y} - {lo_y[EDGE_W-1], lo_y};
        // overlap never exceeds the narrower extent, so it fits EXT_W bits
        ox_next = (hi_x > lo_x) ? dx[EXT_W-1:0] : '0;
        oy_next = (hi_y > lo_y) ? dy[EXT_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= 1'b0;
            tag2_reg <= 1'b0;
            tag3_reg <= 1'b0;
            tag4_reg <= 1'b0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        sum1_reg   <= {1'b0, cand.area} + {1'b0, stored.area};
        inter2_reg <= AREA_W'(ox_reg) * AREA_W'(oy_reg);
        sum2_reg   <= sum1_reg;
        inter3_reg <= inter2_reg;
        uni3_reg   <= sum2_reg - {1'b0, inter2_reg};
        inter4_reg <= inter3_reg;
        prod4_reg  <= PROD_W'(threshold) * PROD_W'(uni3_reg);
    end

    assign lhs = {inter4_reg, {THR_W{1'b0}}};

    assign stat.hit  = tag4_reg && ({1'b0, lhs} > prod4_reg);
    assign stat.busy = tag1_reg | tag2_reg | tag3_reg | tag4_reg;

endmodule

@@ design/greedy_box_suppression.sv @@
// Greedy box suppression top level: input capture, kept-box ring, sequencer, output register.
// Depends on gbs_pkg, gbs_cell and gbs_iou.
//
//  channel   direction  handshake         payload
//  s_        in         s_valid/s_ready   start_frame, box_left/top/width/height
//  m_        out        m_valid/m_ready   keep, box_index, store_overflow
//  apb       in         psel/penable      iou_threshold at byte address 0
//
// A box goes from transfer to result valid in two steps: the stored boxes rotate once past the
// single overlap pipeline, one per cycle, then up to four stages drain, depending on how many
// boxes are stored.
// One box is in work at a time; the next is taken while the last result waits in m_.
// Reset clears the control state and loads the default threshold; the store needs no clearing.
// A stalled m_ side holds the finished box at its last step until the register frees.
module greedy_box_suppression (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_start_frame,
    input  logic signed [gbs_pkg::COORD_WIDTH-1:0] s_box_left,
    input  logic signed [gbs_pkg::COORD_WIDTH-1:0] s_box_top,
    input  logic [gbs_pkg::EXT_W-1:0]    s_box_width,
    input  logic [gbs_pkg::EXT_W-1:0]    s_box_height,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_keep,
    output logic [gbs_pkg::INDEX_W-1:0]  m_box_index,
    output logic                         m_store_overflow,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gbs_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import gbs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [INDEX_W-1:0] frame_idx_reg, frame_idx_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               hit_reg, hit_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    kept_t              cand_reg, cand_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_keep_reg, m_ovf_reg;
    logic [INDEX_W-1:0] m_index_reg;

    logic      accept, cfg_wr, done_fire, store_full, write_en, shift_en, tag;
    iou_stat_t stat;
    kept_t     ring [MAX_KEPT];

    assign accept    = s_valid && s_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign done_fire = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign store_full = (count_reg >= CNT_W'(MAX_KEPT));
    assign write_en  = done_fire && !hit_reg && !store_full;
    assign shift_en  = (state_reg == ST_SCAN);
    assign tag       = shift_en && (scan_reg < count_reg);

    // candidate capture
    always_comb begin
        cand_next = cand_reg;
        if (accept) begin
            cand_next.x0   = EDGE_W'(s_box_left);
            cand_next.y0   = EDGE_W'(s_box_top);
            cand_next.x1   = EDGE_W'(s_box_left) + $signed({2'b00, s_box_width});
            cand_next.y1   = EDGE_W'(s_box_top) + $signed({2'b00, s_box_height});
            cand_next.area = AREA_W'(s_box_width) * AREA_W'(s_box_height);
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        frame_idx_next = frame_idx_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg | stat.hit;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_start_frame) begin
                        count_next     = '0;
                        idx_next       = '0;
                        frame_idx_next = INDEX_W'(1);
                    end else begin
                        idx_next = frame_idx_reg;
                        if (frame_idx_reg != INDEX_MAX) begin
                            frame_idx_next = frame_idx_reg + INDEX_W'(1);
                        end
                    end
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg == CNT_W'(MAX_KEPT - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (done_fire) begin
                    if (write_en) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            frame_idx_reg <= '0;
            hit_reg       <= 1'b0;
            scan_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            frame_idx_reg <= frame_idx_next;
            hit_reg       <= hit_next;
            scan_reg      <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    // kept-box ring: cell i takes from cell i+1, the last wraps to cell 0
    for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
        localparam int NXT = (i + 1) % MAX_KEPT;
        logic load_i;
        assign load_i = write_en && (count_reg[ADDR_W-1:0] == ADDR_W'(i));
        gbs_cell u_cell (
            .aclk    (aclk),
            .shift   (shift_en),
            .load    (load_i),
            .nbr_in  (ring[NXT]),
            .new_in  (cand_reg),
            .rec_out (ring[i])
        );
    end

    gbs_iou u_iou (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (tag),
        .cand      (cand_reg),
        .stored    (ring[0]),
        .threshold (thr_reg),
        .stat      (stat)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (done_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            m_keep_reg  <= !hit_reg;
            m_ovf_reg   <= !hit_reg && store_full;
            m_index_reg <= idx_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_keep           = m_keep_reg;
    assign m_store_overflow = m_ovf_reg;
    assign m_box_index      = m_index_reg;

    // configuration port
    always_comb begin
        thr_next = thr_reg;
        if (cfg_wr && (paddr[2] == REG_IOU_THRESHOLD)) begin
            thr_next = pwdata[THR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else begin
            thr_reg <= thr_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IOU_THRESHOLD) ? {{(32 - THR_W){1'b0}}, thr_reg} : '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond store depth");

    a_ovf_needs_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_store_overflow |-> m_keep)
        else $error("overflow flagged on a suppressed box");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        done_fire |=> (count_reg == $past(count_reg) + (CNT_W)'($past(write_en))))
        else $error("kept count moved by more than one store");

    a_no_scan_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !stat.busy)
        else $error("compare pipeline still busy while idle");
`endif

endmodule
